[hw/rtl/idq_pkg.sv]
package idq_pkg;

	// command codes
	localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
	localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
	localparam logic [3:0] OP_POP_BACK   = 4'd2;
	localparam logic [3:0] OP_POP_FRONT  = 4'd3;
	localparam logic [3:0] OP_READ_BACK  = 4'd4;
	localparam logic [3:0] OP_READ_FRONT = 4'd5;
	localparam logic [3:0] OP_READ_AT    = 4'd6;
	localparam logic [3:0] OP_INSERT_AT  = 4'd7;
	localparam logic [3:0] OP_REMOVE_AT  = 4'd8;
	localparam logic [3:0] OP_CLEAR      = 4'd9;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// shift kinds for the cell row
	localparam logic [1:0] SH_NONE   = 2'd0;
	localparam logic [1:0] SH_INSERT = 2'd1;
	localparam logic [1:0] SH_REMOVE = 2'd2;

	localparam logic signed [31:0] ERR_DATA = -32'sd1;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
	} idq_shift_t;

	typedef struct packed {
		logic               empty_res;
		logic [6:0]         count;
		logic [1:0]         status;
		logic signed [31:0] data;
	} idq_result_t;

endpackage

[hw/rtl/indexed_deque_store.sv]
// indexed deque store: ordered list of up to CAPACITY signed 32-bit values
//
// s_* channel carries one command per transaction (push or pop at either end,
// read an end, read/insert/remove at an index, clear). m_* channel returns
// exactly one result per command: data read or removed (-1 on error),
// status (ok, range/empty, full), count after the command and an empty flag.
//
// storage is a row of cells, one per entry; insert and remove shift every
// cell behind the index by one place at the accepting clock edge, and reads use
// a one-hot tap bus across the row. a command is executed at its accepting
// edge and its result is registered in the output buffer before it shows on
// m_*, so one command per cycle is sustained while the receiver keeps up.
// a two-entry output buffer (result register plus skid register) keeps
// s_tready high while one result waits; if the receiver stalls longer,
// s_tready drops until a result is taken.
// reset empties the store (count 0); entry contents are not cleared and
// never show since only positions below the count are read.
module indexed_deque_store
	import idq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // operation[3:0], position[10:4], value[42:11], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // data[31:0], status[33:32], count[40:34], empty_res[41], pad
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_n;
	logic [CW-1:0] last_c;

	logic [3:0]         operation;
	logic [6:0]         position;
	logic signed [31:0] value;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] cnt_n_x;
	logic            full;
	logic            empty;
	logic            accept;

	logic [1:0]         kind;
	logic [IW-1:0]      at;
	logic signed [31:0] data;
	logic [1:0]         status;
	logic signed [31:0] rd_data;

	idq_shift_t  shift;
	idq_result_t res;
	idq_result_t out_res;

	logic signed [31:0] entry [CAPACITY];
	logic signed [31:0] tap   [CAPACITY];

	assign operation = s_tdata[3:0];
	assign position  = s_tdata[10:4];
	assign value     = s_tdata[42:11];

	assign accept = s_tvalid && s_tready;
	assign pos_x  = CMPW'(position);
	assign cnt_x  = CMPW'(count_q);
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign last_c = count_q - CW'(1);

	// read bus across the row
	always_comb begin
		rd_data = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | tap[i];
		end
	end

	// command decode
	always_comb begin
		kind    = SH_NONE;
		at      = '0;
		data    = 32'sd0;
		status  = ST_OK;
		count_n = count_q;
		unique case (operation) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					kind    = SH_INSERT;
					at      = (operation == OP_PUSH_BACK) ? count_q[IW-1:0] : '0;
					count_n = count_q + CW'(1);
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				at = (operation == OP_POP_BACK) ? last_c[IW-1:0] : '0;
				if (empty) begin
					data   = ERR_DATA;
					status = ST_RANGE;
				end else begin
					kind    = SH_REMOVE;
					data    = rd_data;
					count_n = last_c;
				end
			end
			OP_READ_BACK, OP_READ_FRONT: begin
				at = (operation == OP_READ_BACK) ? last_c[IW-1:0] : '0;
				if (empty) begin
					data   = ERR_DATA;
					status = ST_RANGE;
				end else begin
					data = rd_data;
				end
			end
			OP_READ_AT, OP_REMOVE_AT: begin
				at = pos_x[IW-1:0];
				if (pos_x >= cnt_x) begin
					data   = ERR_DATA;
					status = ST_RANGE;
				end else begin
					data = rd_data;
					if (operation == OP_REMOVE_AT) begin
						kind    = SH_REMOVE;
						count_n = last_c;
					end
				end
			end
			OP_INSERT_AT: begin
				at = pos_x[IW-1:0];
				if (pos_x > cnt_x) begin
					data   = ERR_DATA;
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					kind    = SH_INSERT;
					count_n = count_q + CW'(1);
				end
			end
			OP_CLEAR: begin
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_n;
		end
	end

	assign shift.kind  = accept ? kind : SH_NONE;
	assign shift.value = value;

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left;
		logic signed [31:0] right;
		if (g == 0) begin : g_first
			assign left = value;
		end else begin : g_mid_l
			assign left = entry[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right = entry[g];
		end else begin : g_mid_r
			assign right = entry[g+1];
		end
		idq_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (g)
		) u_cell (
			.clk   (clk),
			.shift (shift),
			.at    (at),
			.left  (left),
			.right (right),
			.entry (entry[g]),
			.tap   (tap[g])
		);
	end

	assign cnt_n_x       = CMPW'(count_n);
	assign res.data      = data;
	assign res.status    = status;
	assign res.count     = cnt_n_x[6:0];
	assign res.empty_res = (count_n == '0);

	idq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_ready  (s_tready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.empty_res, out_res.count, out_res.status, out_res.data};

endmodule

[hw/rtl/idq_cell.sv]
module idq_cell
	import idq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int INDEX    = 0
) (
	input  logic                        clk,
	input  idq_shift_t                  shift,
	input  logic [$clog2(CAPACITY)-1:0] at,
	input  logic signed [31:0]          left,
	input  logic signed [31:0]          right,
	output logic signed [31:0]          entry,
	output logic signed [31:0]          tap
);

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic signed [31:0] entry_q;

	// move toward the back on insert, toward the front on remove
	always_ff @(posedge clk) begin
		case (shift.kind)
			SH_INSERT: begin
				if (MY_IDX > at) begin
					entry_q <= left;
				end else if (MY_IDX == at) begin
					entry_q <= shift.value;
				end
			end
			SH_REMOVE: begin
				if (MY_IDX >= at) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	// contributes to the read bus only when addressed
	assign tap = (MY_IDX == at) ? entry_q : 32'sd0;

endmodule

[hw/rtl/idq_outbuf.sv]
module idq_outbuf
	import idq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  idq_result_t in_res,
	output logic        out_valid,
	input  logic        out_ready,
	output idq_result_t out_res
);

	logic        out_valid_q;
	logic        skid_valid_q;
	idq_result_t out_q;
	idq_result_t skid_q;

	assign in_ready = !skid_valid_q;

	// control: main register refills from skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

[sim/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import idq_pkg::*;

	localparam int STORE_CAPACITY = 64;
	localparam int MAX_GAP = 17;
	localparam int MAX_REPORTS = 10;
	localparam logic [3:0] OP_UNUSED_LO = OP_CLEAR + 4'd1;
	localparam logic [3:0] OP_UNUSED_HI = 4'hF;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // operation[3:0], position[10:4], value[42:11], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // data[31:0], status[33:32], count[40:34], empty_res[41], pad

	// shadow copy of the stored entries, front at index 0
	logic signed [31:0] shadow_entries[$];
	idq_result_t        expected_results[$];
	int                 fail_count = 0;
	bit                 steady_flow = 1'b0;

	indexed_deque_store #(
		.CAPACITY(STORE_CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// idle cycles before the next transaction on either side
	function automatic int draw_gap();
		return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// apply one command to the shadow store and return its result
	function automatic idq_result_t predict_command(input logic [3:0] op,
			input logic [6:0] pos, input logic signed [31:0] val);
		idq_result_t res;
		int depth;
		depth = shadow_entries.size();
		res.data = '0;
		res.status = ST_OK;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (depth >= STORE_CAPACITY)
					res.status = ST_FULL;
				else if (op == OP_PUSH_BACK)
					shadow_entries.push_back(val);
				else
					shadow_entries.push_front(val);
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (depth == 0) begin
					res.data = ERR_DATA;
					res.status = ST_RANGE;
				end else if (op == OP_POP_BACK) begin
					res.data = shadow_entries.pop_back();
				end else begin
					res.data = shadow_entries.pop_front();
				end
			end
			OP_READ_BACK, OP_READ_FRONT: begin
				if (depth == 0) begin
					res.data = ERR_DATA;
					res.status = ST_RANGE;
				end else begin
					res.data = (op == OP_READ_BACK) ? shadow_entries[depth - 1] :
						shadow_entries[0];
				end
			end
			OP_READ_AT, OP_REMOVE_AT: begin
				if (int'(pos) >= depth) begin
					res.data = ERR_DATA;
					res.status = ST_RANGE;
				end else begin
					res.data = shadow_entries[pos];
					if (op == OP_REMOVE_AT)
						shadow_entries.delete(pos);
				end
			end
			OP_INSERT_AT: begin
				// range check wins over the full check
				if (int'(pos) > depth) begin
					res.data = ERR_DATA;
					res.status = ST_RANGE;
				end else if (depth >= STORE_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_entries.insert(pos, val);
				end
			end
			OP_CLEAR: begin
				shadow_entries.delete();
			end
			default: begin
				// unused codes leave the store alone
			end
		endcase
		res.count = 7'(shadow_entries.size());
		res.empty_res = (shadow_entries.size() == 0);
		return res;
	endfunction

	// drive one command and wait for its transaction
	task automatic send_command(input logic [3:0] op, input logic [6:0] pos,
			input logic signed [31:0] val);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, val, pos, op};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_command(op, pos, val));
	endtask

	// hold off the sender until every result is back
	task automatic wait_store_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// result side backpressure
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		idq_result_t got;
		idq_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = idq_result_t'(m_tdata[41:0]);
			if (expected_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected result: data %0d status %0d count %0d empty %0b",
						got.data, got.status, got.count, got.empty_res);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.data !== want.data || got.status !== want.status ||
						got.count !== want.count || got.empty_res !== want.empty_res) begin
					if (fail_count < MAX_REPORTS) begin
						$display("mismatch exp: data %0d status %0d count %0d empty %0b",
							want.data, want.status, want.count, want.empty_res);
						$display("         got: data %0d status %0d count %0d empty %0b",
							got.data, got.status, got.count, got.empty_res);
					end
					fail_count++;
				end
			end
		end
	end

	// reads, pops and removals on a store with nothing in it, an insert past the end, unused codes and a clear
	task automatic test_empty_store();
		send_command(OP_POP_BACK, 7'd0, 32'sd5);
		send_command(OP_POP_FRONT, 7'd0, 32'sd5);
		send_command(OP_READ_BACK, 7'd0, 32'sd0);
		send_command(OP_READ_FRONT, 7'h7F, 32'sd0);
		send_command(OP_READ_AT, 7'd0, 32'sd0);
		send_command(OP_REMOVE_AT, 7'd0, 32'sd0);
		send_command(OP_INSERT_AT, 7'd1, 32'sd9);
		send_command(OP_UNUSED_LO, 7'h7F, -32'sd1);
		send_command(OP_UNUSED_HI, 7'd0, 32'sd0);
		send_command(OP_CLEAR, 7'd0, 32'sd0);
	endtask

	// push, read and pop at both ends with extreme values
	task automatic test_end_access();
		send_command(OP_PUSH_BACK, 7'h7F, 32'sh7FFF_FFFF);
		send_command(OP_PUSH_FRONT, 7'd0, 32'sh8000_0000);
		send_command(OP_PUSH_BACK, 7'd0, -32'sd1);
		send_command(OP_PUSH_BACK, 7'h55, 32'sd0);
		send_command(OP_READ_FRONT, 7'd0, 32'sd0);
		send_command(OP_READ_BACK, 7'd0, 32'sd0);
		send_command(OP_POP_FRONT, 7'd0, 32'sd0);
		send_command(OP_POP_BACK, 7'd0, 32'sd0);
	endtask

	// indexed access at the front, in the middle, at the end and past it
	task automatic test_indexed_access();
		send_command(OP_INSERT_AT, 7'd2, 32'sh1234_5678);
		send_command(OP_INSERT_AT, 7'd0, 32'shA5A5_5A5A);
		send_command(OP_INSERT_AT, 7'd5, 32'sd77);
		send_command(OP_READ_AT, 7'd3, 32'sd0);
		send_command(OP_READ_AT, 7'd4, 32'sd0);
		send_command(OP_REMOVE_AT, 7'd1, 32'sd0);
		send_command(OP_REMOVE_AT, 7'd3, 32'sd0);
		send_command(OP_READ_AT, 7'h7F, 32'sd0);
		send_command(OP_REMOVE_AT, 7'd0, 32'sd0);
		send_command(OP_CLEAR, 7'd0, 32'sd0);
	endtask

	// random commands; grow_pct sets how often an entry gets added
	task automatic random_traffic(input int items, input int grow_pct);
		logic [3:0]         op;
		logic [6:0]         pos;
		logic signed [31:0] val;
		int                 r;
		int                 depth;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 39) == 0)
				steady_flow = !steady_flow;

			// pick the command
			r = $urandom_range(0, 99);
			if (r < grow_pct) begin
				case ($urandom_range(0, 2))
					0: op = OP_PUSH_BACK;
					1: op = OP_PUSH_FRONT;
					default: op = OP_INSERT_AT;
				endcase
			end else if (r < grow_pct + 1) begin
				op = OP_CLEAR;
			end else if (r < grow_pct + 3) begin
				op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			end else begin
				case ($urandom_range(0, 6))
					0: op = OP_POP_BACK;
					1: op = OP_POP_FRONT;
					2: op = OP_READ_BACK;
					3: op = OP_READ_FRONT;
					4: op = OP_READ_AT;
					default: op = OP_REMOVE_AT;
				endcase
			end

			// index mostly in range, sometimes at the count, sometimes anywhere
			depth = shadow_entries.size();
			r = $urandom_range(0, 19);
			if (r < 14)
				pos = 7'($urandom_range(0, depth));
			else if (r < 17)
				pos = 7'(depth);
			else
				pos = 7'($urandom_range(0, 127));

			// value with the odd extreme mixed in
			case ($urandom_range(0, 15))
				0: val = 32'sh7FFF_FFFF;
				1: val = 32'sh8000_0000;
				2: val = -32'sd1;
				3: val = 32'sd0;
				default: val = $urandom;
			endcase

			send_command(op, pos, val);
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_grow_to_full();
		random_traffic(400, 65);
	endtask

	// sit at the capacity limit so refused pushes and inserts show up
	task automatic test_full_boundary();
		random_traffic(250, 85);
	endtask

	task automatic test_drain_to_empty();
		random_traffic(400, 20);
	endtask

	task automatic test_mixed_traffic();
		random_traffic(600, 48);
	endtask

	// reset, then the tests in turn
	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_end_access();
		test_indexed_access();
		wait_store_idle();
		test_grow_to_full();
		test_full_boundary();
		wait_store_idle();
		test_drain_to_empty();
		test_mixed_traffic();

		wait_store_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/idq_pkg.sv
hw/rtl/idq_cell.sv
hw/rtl/idq_outbuf.sv
hw/rtl/indexed_deque_store.sv
sim/tb_top.sv
